### sv/cce_pkg.sv
package cce_pkg;

    // Store geometry and degree limit
    localparam int MAX_ORDER   = 7;
    localparam int STORE_DIM   = 8;
    localparam int STORE_DEPTH = 64;
    localparam int DIM_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int ORD_CAP     = (MAX_ORDER < STORE_DIM - 1) ? MAX_ORDER : STORE_DIM - 1;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y   = 3'd4;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] poly_value;
        logic               saturated;
    } t_out_item;

    // Combine modes of the shared multiply-add unit
    typedef enum logic [1:0] {
        MAC_MAP,
        MAC_STEP,
        MAC_LAST
    } t_mac_op;

    typedef struct packed {
        logic    mul_en;
        t_mac_op op;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAPX_MUL,
        ST_MAPX_ACC,
        ST_MAPY_MUL,
        ST_MAPY_ACC,
        ST_MUL,
        ST_ACC
    } t_state;

endpackage

### sv/cce_ram.sv
module cce_ram #(
    parameter int WIDTH = cce_pkg::DATA_W,
    parameter int DEPTH = cce_pkg::STORE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cce_mac.sv
module cce_mac (
    input  logic               i_clk,
    input  cce_pkg::t_mac_ctl  i_ctl,
    input  logic signed [31:0] i_mul_a,
    input  logic signed [31:0] i_mul_b,
    input  logic signed [31:0] i_add,
    input  logic signed [31:0] i_sub,
    output logic signed [31:0] o_res,
    output logic               o_sat
);

    localparam logic signed [65:0] RND_MAP  = 66'sh800;
    localparam logic signed [65:0] RND_STEP = 66'sh10000000;
    localparam logic signed [65:0] RND_LAST = 66'sh20000000;
    localparam logic signed [65:0] LIM_HI   = 66'sh7FFFFFFF;
    localparam logic signed [65:0] LIM_LO   = -66'sh80000000;

    logic signed [63:0] r_prod;
    logic signed [65:0] w_prod;
    logic signed [65:0] w_shift;
    logic signed [65:0] w_sum;

    // Register the product of the two operands
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_mul_a * i_mul_b;
        end
    end

    // Round half up, drop fraction bits, add and subtract, clip to 32 bits
    always_comb begin
        w_prod = {{2{r_prod[63]}}, r_prod};
        case (i_ctl.op)
            cce_pkg::MAC_STEP: w_shift = (w_prod + RND_STEP) >>> 29;
            cce_pkg::MAC_LAST: w_shift = (w_prod + RND_LAST) >>> 30;
            default:           w_shift = (w_prod + RND_MAP) >>> 12;
        endcase
        w_sum = w_shift + {{34{i_add[31]}}, i_add} - {{34{i_sub[31]}}, i_sub};
        if (w_sum > LIM_HI) begin
            o_res = 32'sh7FFFFFFF;
            o_sat = 1'b1;
        end else if (w_sum < LIM_LO) begin
            o_res = 32'sh80000000;
            o_sat = 1'b1;
        end else begin
            o_res = w_sum[31:0];
            o_sat = 1'b0;
        end
    end

endmodule

### sv/chebyshev_2d_clenshaw_eval.sv
// 2-D Chebyshev evaluator with a Clenshaw sequencer over one shared 32x32 multiplier.
// An item is accepted when start is high and busy is low. A write item (opcode 0)
// stores one Q8.24 coefficient at address y_degree*8 + x_degree and gives no result;
// busy stays low. An evaluate item (opcode 1) holds busy through the map of each axis
// and the Clenshaw steps from degree n down to zero of every row pass in x and of the
// final pass in y, n being poly_order capped at the maximum order; each map and step is
// a multiply, then a round-add-clip, paced by the single multiply-add unit. The result
// appears on o_result for exactly one cycle with o_strobe high, in the first cycle with
// busy low again; the receiver cannot stall it, so it must take it then.
// The coefficient store reads as zero after reset until written. Configuration writes
// are always ready; the user must make them only while the block is idle, unchecked.
module chebyshev_2d_clenshaw_eval #(
    parameter int MAX_ORDER = cce_pkg::MAX_ORDER
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  cce_pkg::t_in_item                    i_item,
    output logic                                 o_strobe,
    output cce_pkg::t_out_item                   o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cce_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    localparam int ORD_CAP = (MAX_ORDER < cce_pkg::STORE_DIM - 1) ? MAX_ORDER
                                                                  : cce_pkg::STORE_DIM - 1;
    localparam logic [cce_pkg::DIM_W-1:0] ORD_LIM = ORD_CAP[cce_pkg::DIM_W-1:0];

    cce_pkg::t_state   r_state, n_state;
    logic [2:0]        r_poly_order;
    logic signed [31:0] r_scale_x, r_offset_x, r_scale_y, r_offset_y;
    logic [cce_pkg::STORE_DEPTH-1:0] r_cvalid;
    logic              r_rd_ok;
    logic              r_strobe, n_strobe;

    logic signed [31:0] r_x, n_x, r_y, n_y;
    logic signed [31:0] r_ux, n_ux, r_uy, n_uy;
    logic signed [31:0] r_b1, n_b1, r_b2, n_b2;
    logic [cce_pkg::DIM_W-1:0] r_k, n_k, r_j, n_j, r_ord, n_ord;
    logic              r_pass_y, n_pass_y;
    logic              r_sat, n_sat;
    logic signed [31:0] r_res, n_res;
    logic              r_out_sat, n_out_sat;
    logic signed [31:0] r_rows [cce_pkg::STORE_DIM];
    logic              w_rows_we;

    logic              w_accept;
    logic              w_wr;
    logic [cce_pkg::DIM_W-1:0] w_ord;
    logic [cce_pkg::ADDR_W-1:0] w_raddr;
    logic [31:0]       w_rdata;
    logic signed [31:0] w_u, w_g;

    cce_pkg::t_mac_ctl w_mac_ctl;
    logic signed [31:0] w_mul_a, w_mul_b, w_add, w_sub, w_mac_res;
    logic              w_mac_sat;

    assign busy        = (r_state != cce_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_wr        = w_accept && (i_item.opcode == cce_pkg::OP_WRITE);
    assign w_ord       = (r_poly_order > ORD_LIM) ? ORD_LIM : r_poly_order;
    assign w_raddr     = {r_j, r_k};

    cce_ram #(
        .WIDTH(cce_pkg::DATA_W),
        .DEPTH(cce_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_wr),
        .i_waddr(i_item.coef_index),
        .i_wdata(i_item.coef_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    cce_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_mul_a(w_mul_a),
        .i_mul_b(w_mul_b),
        .i_add  (w_add),
        .i_sub  (w_sub),
        .o_res  (w_mac_res),
        .o_sat  (w_mac_sat)
    );

    // Hold control state, configuration and coefficient valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cce_pkg::ST_IDLE;
            r_strobe     <= 1'b0;
            r_cvalid     <= '0;
            r_poly_order <= 3'd0;
            r_scale_x    <= 32'sh40000000;
            r_offset_x   <= 32'sh0;
            r_scale_y    <= 32'sh40000000;
            r_offset_y   <= 32'sh0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (w_wr) begin
                r_cvalid[i_item.coef_index] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cce_pkg::CFG_POLY_ORDER: r_poly_order <= i_cfg_data[2:0];
                    cce_pkg::CFG_SCALE_X:    r_scale_x    <= i_cfg_data;
                    cce_pkg::CFG_OFFSET_X:   r_offset_x   <= i_cfg_data;
                    cce_pkg::CFG_SCALE_Y:    r_scale_y    <= i_cfg_data;
                    cce_pkg::CFG_OFFSET_Y:   r_offset_y   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Advance the datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_ok   <= r_cvalid[w_raddr];
        r_x       <= n_x;
        r_y       <= n_y;
        r_ux      <= n_ux;
        r_uy      <= n_uy;
        r_b1      <= n_b1;
        r_b2      <= n_b2;
        r_k       <= n_k;
        r_j       <= n_j;
        r_ord     <= n_ord;
        r_pass_y  <= n_pass_y;
        r_sat     <= n_sat;
        r_res     <= n_res;
        r_out_sat <= n_out_sat;
        if (w_rows_we) begin
            r_rows[r_j] <= w_mac_res;
        end
    end

    // Sequence the maps, the row passes in x and the final pass in y
    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_x       = r_x;
        n_y       = r_y;
        n_ux      = r_ux;
        n_uy      = r_uy;
        n_b1      = r_b1;
        n_b2      = r_b2;
        n_k       = r_k;
        n_j       = r_j;
        n_ord     = r_ord;
        n_pass_y  = r_pass_y;
        n_sat     = r_sat;
        n_res     = r_res;
        n_out_sat = r_out_sat;
        w_rows_we = 1'b0;

        w_u = r_pass_y ? r_uy : r_ux;
        w_g = r_pass_y ? r_rows[r_k] : (r_rd_ok ? w_rdata : 32'sh0);

        w_mac_ctl.mul_en = 1'b0;
        w_mac_ctl.op     = cce_pkg::MAC_MAP;
        w_mul_a          = r_scale_x;
        w_mul_b          = r_x;
        w_add            = r_offset_x;
        w_sub            = 32'sh0;

        case (r_state)
            cce_pkg::ST_IDLE: begin
                if (w_accept && (i_item.opcode == cce_pkg::OP_EVAL)) begin
                    n_x      = i_item.x_coord;
                    n_y      = i_item.y_coord;
                    n_ord    = w_ord;
                    n_sat    = 1'b0;
                    n_pass_y = 1'b0;
                    n_j      = '0;
                    n_state  = cce_pkg::ST_MAPX_MUL;
                end
            end
            cce_pkg::ST_MAPX_MUL: begin
                w_mac_ctl.mul_en = 1'b1;
                n_state          = cce_pkg::ST_MAPX_ACC;
            end
            cce_pkg::ST_MAPX_ACC: begin
                n_ux    = w_mac_res;
                n_sat   = r_sat | w_mac_sat;
                n_state = cce_pkg::ST_MAPY_MUL;
            end
            cce_pkg::ST_MAPY_MUL: begin
                w_mul_a          = r_scale_y;
                w_mul_b          = r_y;
                w_mac_ctl.mul_en = 1'b1;
                n_state          = cce_pkg::ST_MAPY_ACC;
            end
            cce_pkg::ST_MAPY_ACC: begin
                w_add   = r_offset_y;
                n_uy    = w_mac_res;
                n_sat   = r_sat | w_mac_sat;
                n_k     = r_ord;
                n_b1    = 32'sh0;
                n_b2    = 32'sh0;
                n_state = cce_pkg::ST_MUL;
            end
            cce_pkg::ST_MUL: begin
                w_mul_a          = r_b1;
                w_mul_b          = w_u;
                w_mac_ctl.mul_en = 1'b1;
                n_state          = cce_pkg::ST_ACC;
            end
            cce_pkg::ST_ACC: begin
                w_mac_ctl.op = (r_k == '0) ? cce_pkg::MAC_LAST : cce_pkg::MAC_STEP;
                w_add        = w_g;
                w_sub        = r_b2;
                n_sat        = r_sat | w_mac_sat;
                if (r_k != '0) begin
                    // Shift the recurrence and step one degree down
                    n_b2    = r_b1;
                    n_b1    = w_mac_res;
                    n_k     = r_k - 1'b1;
                    n_state = cce_pkg::ST_MUL;
                end else if (!r_pass_y) begin
                    // Store the row result, then start the next row or the y pass
                    w_rows_we = 1'b1;
                    n_k       = r_ord;
                    n_b1      = 32'sh0;
                    n_b2      = 32'sh0;
                    if (r_j == r_ord) begin
                        n_pass_y = 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                    n_state = cce_pkg::ST_MUL;
                end else begin
                    // Deliver the item's result
                    n_res     = w_mac_res;
                    n_out_sat = r_sat | w_mac_sat;
                    n_strobe  = 1'b1;
                    n_state   = cce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cce_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_strobe            = r_strobe;
    assign o_result.poly_value = r_res;
    assign o_result.saturated  = r_out_sat;

endmodule
